@@ hw/rtl/rfp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the rangefinder frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

	localparam logic [7:0]  SYNC_BYTE    = 8'hFB;
	localparam logic [7:0]  MEASURE_CODE = 8'h03;
	localparam logic [15:0] OPEN_SPACE   = 16'hFFFF;
	localparam logic [3:0]  LAST_POS     = 4'd8;
	localparam logic [3:0]  POS_CODE     = 4'd1;
	localparam logic [3:0]  POS_DIST_LO  = 4'd6;
	localparam logic [3:0]  POS_DIST_HI  = 4'd7;
	localparam logic [3:0]  POS_HUNT     = 4'd0;

	localparam int LIMIT_W = 4;
	localparam int SCALE_W = 10;
	localparam int MM_W    = 26;
	localparam int CFG_IDX_W = 1;

	localparam logic [LIMIT_W-1:0] FAIL_LIMIT_RST = 4'd5;
	localparam logic [SCALE_W-1:0] SCALE_RST      = 10'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FAIL_LIMIT     = 1'b0,
		REG_DISTANCE_SCALE = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		STS_DISTANCE    = 3'd0,
		STS_NO_OBJECT   = 3'd1,
		STS_OPEN_SPACE  = 3'd2,
		STS_OTHER       = 3'd3,
		STS_CSUM_ERR    = 3'd4,
		STS_CSUM_REOPEN = 3'd5
	} status_t;

	// finished frame handed from the framer to the result stage
	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [7:0]  code;
		logic [15:0] raw;
	} frame_rec_t;

endpackage

@@ hw/rtl/rfp_framer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_framer
// Sync hunt, byte capture, checksum check and failure counting; registers
// one record per completed frame.
// ----------------------------------------------------------------------------
module rfp_framer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic [7:0]                  rx_byte,
	input  logic [rfp_pkg::LIMIT_W-1:0] fail_limit,
	input  logic                        advance,
	output rfp_pkg::frame_rec_t         rec_s1
);
	import rfp_pkg::*;

	logic [3:0]         pos_q, pos_d;
	logic [7:0]         sum_q, sum_d;
	logic [7:0]         code_q, code_d;
	logic [7:0]         dlo_q, dlo_d;
	logic [7:0]         dhi_q, dhi_d;
	logic [LIMIT_W-1:0] fail_q, fail_d;
	logic               done;
	status_t            status_n;
	logic [LIMIT_W:0]   fail_next;
	logic [15:0]        raw;
	logic               rec_valid_s1;
	status_t            rec_status_s1;
	logic [7:0]         rec_code_s1;
	logic [15:0]        rec_raw_s1;

	assign raw       = {dhi_q, dlo_q};
	assign fail_next = {1'b0, fail_q} + {{LIMIT_W{1'b0}}, 1'b1};

	assign rec_s1 = '{valid: rec_valid_s1, status: rec_status_s1, code: rec_code_s1,
	                  raw: rec_raw_s1};

	always_comb begin
		pos_d    = pos_q;
		sum_d    = sum_q;
		code_d   = code_q;
		dlo_d    = dlo_q;
		dhi_d    = dhi_q;
		fail_d   = fail_q;
		done     = 1'b0;
		status_n = STS_OTHER;
		if (accept) begin
			if (pos_q == POS_HUNT || pos_q > LAST_POS) begin
				// drop everything but sync while hunting
				if (rx_byte == SYNC_BYTE) begin
					sum_d = rx_byte;
					pos_d = POS_CODE;
				end else begin
					pos_d = POS_HUNT;
				end
			end else if (pos_q < LAST_POS) begin
				if (pos_q == POS_CODE)
					code_d = rx_byte;
				if (pos_q == POS_DIST_LO)
					dlo_d = rx_byte;
				if (pos_q == POS_DIST_HI)
					dhi_d = rx_byte;
				sum_d = sum_q + rx_byte;
				pos_d = pos_q + 4'd1;
			end else begin
				pos_d = POS_HUNT;
				done  = 1'b1;
				if (sum_q != rx_byte) begin
					if (fail_next > {1'b0, fail_limit}) begin
						fail_d   = '0;
						status_n = STS_CSUM_REOPEN;
					end else begin
						fail_d   = fail_next[LIMIT_W-1:0];
						status_n = STS_CSUM_ERR;
					end
				end else begin
					fail_d = '0;
					if (code_q != MEASURE_CODE)
						status_n = STS_OTHER;
					else if (raw == 16'd0)
						status_n = STS_NO_OBJECT;
					else if (raw == OPEN_SPACE)
						status_n = STS_OPEN_SPACE;
					else
						status_n = STS_DISTANCE;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HUNT;
			sum_q  <= '0;
			code_q <= '0;
			dlo_q  <= '0;
			dhi_q  <= '0;
			fail_q <= '0;
			rec_valid_s1 <= 1'b0;
		end else begin
			pos_q  <= pos_d;
			sum_q  <= sum_d;
			code_q <= code_d;
			dlo_q  <= dlo_d;
			dhi_q  <= dhi_d;
			fail_q <= fail_d;
			// hold the record while the result stage is stalled
			if (advance || !rec_valid_s1)
				rec_valid_s1 <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rec_status_s1 <= status_n;
			rec_code_s1   <= code_q;
			rec_raw_s1    <= raw;
		end
	end

endmodule

@@ hw/rtl/rfp_result.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_result
// Scales the raw distance and holds the result beat for the output channel.
// ----------------------------------------------------------------------------
module rfp_result (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rfp_pkg::frame_rec_t         rec_s1,
	input  logic [rfp_pkg::SCALE_W-1:0] distance_scale,
	output logic                        advance,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [2:0]                  frame_status,
	output logic [rfp_pkg::MM_W-1:0]    distance_mm,
	output logic [7:0]                  message_code
);
	import rfp_pkg::*;

	logic            valid_q;
	status_t         status_q;
	logic [MM_W-1:0] mm_q;
	logic [7:0]      code_q;
	logic [MM_W-1:0] mm_n;

	assign advance = !valid_q || !out_stall;
	assign mm_n    = (rec_s1.status == STS_DISTANCE) ?
	                 MM_W'(rec_s1.raw * distance_scale) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (advance)
			valid_q <= rec_s1.valid;
	end

	always_ff @(posedge clk) begin
		if (advance && rec_s1.valid) begin
			status_q <= rec_s1.status;
			mm_q     <= mm_n;
			code_q   <= rec_s1.code;
		end
	end

	assign out_valid    = valid_q;
	assign frame_status = status_q;
	assign distance_mm  = mm_q;
	assign message_code = code_q;

endmodule

@@ hw/rtl/rangefinder_frame_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rangefinder_frame_parser_core
// Parses 9-byte rangefinder frames from a stream of received bytes and
// reports one result beat per completed frame.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | rx_byte
//  out     | out_valid / out_stall | frame_status, distance_mm, message_code
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One byte is taken every cycle that in_valid is high and in_stall is low; a
// frame's result passes from its checksum byte through the framer record and
// then the multiply and output register. in_stall rises only while a finished record waits behind
// a stalled output beat. Reset clears framing state, failure count and
// valids, and loads fail_limit 5 and distance_scale 100. cfg_ready is always
// high.
module rangefinder_frame_parser_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    frame_status,
	output logic [rfp_pkg::MM_W-1:0]      distance_mm,
	output logic [7:0]                    message_code,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfp_pkg::SCALE_W-1:0]   cfg_data
);
	import rfp_pkg::*;

	logic [LIMIT_W-1:0] fail_limit_q;
	logic [SCALE_W-1:0] distance_scale_q;
	frame_rec_t         rec_s1;
	logic               advance;
	logic               accept;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_limit_q     <= FAIL_LIMIT_RST;
			distance_scale_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FAIL_LIMIT:     fail_limit_q     <= cfg_data[LIMIT_W-1:0];
				REG_DISTANCE_SCALE: distance_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = rec_s1.valid && !advance;
	assign accept   = in_valid && !in_stall;

	rfp_framer u_framer (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.rx_byte    (rx_byte),
		.fail_limit (fail_limit_q),
		.advance    (advance),
		.rec_s1     (rec_s1)
	);

	rfp_result u_result (
		.clk            (clk),
		.arst_n         (arst_n),
		.rec_s1         (rec_s1),
		.distance_scale (distance_scale_q),
		.advance        (advance),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.distance_mm    (distance_mm),
		.message_code   (message_code)
	);

	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall && rec_s1.valid))
		else $error("input stalled without a blocked record");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (frame_status <= STS_CSUM_REOPEN))
		else $error("frame status out of range");

	a_mm_zero_unless_distance: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_status != STS_DISTANCE) |-> (distance_mm == '0))
		else $error("distance nonzero for non-distance status");

	a_record_held: assert property (@(posedge clk) disable iff (!arst_n)
		(rec_s1.valid && !advance) |=> (rec_s1.valid && $stable(rec_s1)))
		else $error("pending frame record lost or changed");

endmodule

@@ tb/sv/rfp_frame_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_frame_checker
// Watches the byte, result and register channels of the rangefinder frame
// parser. It tracks the framing state from every accepted byte and queues the
// result of each finished frame. Each result beat is compared field by field
// with the oldest queued frame.
// ----------------------------------------------------------------------------
module rfp_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic [7:0]                    rx_byte,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [2:0]                    frame_status,
	input  logic [rfp_pkg::MM_W-1:0]      distance_mm,
	input  logic [7:0]                    message_code,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rfp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rfp_pkg::SCALE_W-1:0]   cfg_data,
	output int                            frames_pending,
	output int                            error_count
);
	import rfp_pkg::*;

	typedef struct {
		status_t          status;
		logic [MM_W-1:0]  mm;
		logic [7:0]       code;
	} frame_result_t;

	frame_result_t expected_frames [$];
	frame_result_t want;
	frame_result_t got;
	int            errors;

	logic [LIMIT_W-1:0] limit_cfg;
	logic [SCALE_W-1:0] scale_cfg;
	logic [3:0]         frame_pos;
	logic [7:0]         sum_so_far;
	logic [7:0]         code_seen;
	logic [7:0]         dist_lo;
	logic [7:0]         dist_hi;
	logic [3:0]         fail_run;

	// Advance the framer by one byte; returns 1 when the byte closes a frame.
	function automatic bit take_rx_byte(input logic [7:0] b, output frame_result_t res);
		logic [4:0]  next_fail;
		logic [15:0] raw;
		res = '{STS_DISTANCE, '0, '0};
		if (frame_pos == POS_HUNT || frame_pos > LAST_POS) begin
			if (b == SYNC_BYTE) begin
				sum_so_far = b;
				frame_pos  = POS_CODE;
			end else begin
				frame_pos = POS_HUNT;
			end
			return 1'b0;
		end
		if (frame_pos < LAST_POS) begin
			case (frame_pos)
				POS_CODE: begin
					code_seen = b;
				end
				POS_DIST_LO: begin
					dist_lo = b;
				end
				POS_DIST_HI: begin
					dist_hi = b;
				end
				default: begin
				end
			endcase
			sum_so_far = sum_so_far + b;
			frame_pos  = frame_pos + 4'd1;
			return 1'b0;
		end
		// checksum byte
		frame_pos = POS_HUNT;
		res.code  = code_seen;
		if (sum_so_far != b) begin
			// compare one bit wider so a limit of fifteen never wraps
			next_fail = {1'b0, fail_run} + 5'd1;
			if (next_fail > {1'b0, limit_cfg}) begin
				fail_run   = '0;
				res.status = STS_CSUM_REOPEN;
			end else begin
				fail_run   = next_fail[3:0];
				res.status = STS_CSUM_ERR;
			end
		end else begin
			fail_run = '0;
			raw      = {dist_hi, dist_lo};
			if (code_seen != MEASURE_CODE) begin
				res.status = STS_OTHER;
			end else if (raw == '0) begin
				res.status = STS_NO_OBJECT;
			end else if (raw == OPEN_SPACE) begin
				res.status = STS_OPEN_SPACE;
			end else begin
				res.status = STS_DISTANCE;
				res.mm     = MM_W'(raw) * MM_W'(scale_cfg);
			end
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg  = FAIL_LIMIT_RST;
			scale_cfg  = SCALE_RST;
			frame_pos  = POS_HUNT;
			sum_so_far = '0;
			code_seen  = '0;
			dist_lo    = '0;
			dist_hi    = '0;
			fail_run   = '0;
			errors     = 0;
			expected_frames.delete();
			frames_pending <= 0;
			error_count    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FAIL_LIMIT: begin
						limit_cfg = cfg_data[LIMIT_W-1:0];
					end
					REG_DISTANCE_SCALE: begin
						scale_cfg = cfg_data;
					end
					default: begin
					end
				endcase
			end
			// check the result beat before queueing a new frame
			if (out_valid && !out_stall) begin
				if (expected_frames.size() == 0) begin
					$error("result beat with no frame pending: frame_status %0d", frame_status);
					errors++;
				end else begin
					want = expected_frames.pop_front();
					if (frame_status !== want.status) begin
						$error("frame_status: expected %0d, actual %0d", want.status, frame_status);
						errors++;
					end
					if (distance_mm !== want.mm) begin
						$error("distance_mm: expected %0d, actual %0d", want.mm, distance_mm);
						errors++;
					end
					if (message_code !== want.code) begin
						$error("message_code: expected 0x%02h, actual 0x%02h", want.code,
							message_code);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				if (take_rx_byte(rx_byte, got)) begin
					expected_frames.push_back(got);
				end
			end
			frames_pending <= expected_frames.size();
			error_count    <= errors;
		end
	end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the rangefinder frame parser with a short directed set of frames and
// then phases of random frames and line noise, each phase under its own
// register setting. Both channels idle and stall in random bursts; the last
// phase runs at full rate. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
	import rfp_pkg::*;

	localparam int WATCHDOG_LIMIT = 400;
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_CYCLES     = 8;
	localparam int PHASES         = 8;

	localparam int LIMIT_TAB [PHASES] = '{0, 15, 15, 1, 0, 0, 5, 0};
	localparam int SCALE_TAB [PHASES] = '{1, 1023, 0, 1000, 0, 0, 100, 0};
	localparam bit DRAW_TAB  [PHASES] = '{0, 0, 0, 0, 1, 1, 0, 1};
	localparam int BAD_TAB   [PHASES] = '{40, 100, 20, 50, 30, 30, 30, 25};
	localparam int COUNT_TAB [PHASES] = '{16, 18, 14, 16, 16, 16, 16, 18};
	localparam int IDLE_TAB  [PHASES] = '{20, 30, 0, 15, 40, 10, 25, 0};
	localparam int STALL_TAB [PHASES] = '{25, 0, 35, 15, 40, 20, 10, 0};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         rx_byte = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         frame_status;
	logic [MM_W-1:0]    distance_mm;
	logic [7:0]         message_code;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	cfg_reg_t           cfg_index = REG_FAIL_LIMIT;
	logic [SCALE_W-1:0] cfg_data = '0;

	int frames_pending;
	int check_errors;
	int idle_pct  = 0;
	int stall_pct = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rangefinder_frame_parser_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.distance_mm  (distance_mm),
		.message_code (message_code),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	rfp_frame_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.rx_byte        (rx_byte),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.frame_status   (frame_status),
		.distance_mm    (distance_mm),
		.message_code   (message_code),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.frames_pending (frames_pending),
		.error_count    (check_errors)
	);

	// result side: stall in random bursts
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_stall  <= 1'b1;
		end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
			stall_left <= $urandom_range(6);
			out_stall  <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	task automatic send_byte(input logic [7:0] value);
		if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= value;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic send_frame(input logic [7:0] code, input logic [15:0] raw, input bit corrupt);
		logic [7:0] frame [9];
		logic [7:0] sum;
		frame[0] = SYNC_BYTE;
		frame[1] = code;
		for (int i = 2; i < 6; i++) frame[i] = 8'($urandom);
		frame[6] = raw[7:0];
		frame[7] = raw[15:8];
		sum = '0;
		for (int i = 0; i < 8; i++) sum = sum + frame[i];
		frame[8] = corrupt ? sum + 8'($urandom_range(1, 255)) : sum;
		foreach (frame[i]) send_byte(frame[i]);
	endtask

	function automatic logic [15:0] pick_raw();
		case ($urandom_range(5))
			0: return 16'h0000;
			1: return OPEN_SPACE;
			2: return OPEN_SPACE - 16'd1;
			3: return 16'h0001;
			default: return 16'($urandom);
		endcase
	endfunction

	// Hold the byte stream, let every frame drain, then load both registers.
	task automatic reconfigure(input logic [LIMIT_W-1:0] limit, input logic [SCALE_W-1:0] scale);
		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_FAIL_LIMIT;
		cfg_data  <= {6'($urandom), limit};
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_DISTANCE_SCALE;
		cfg_data  <= scale;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [LIMIT_W-1:0] limit;
		logic [SCALE_W-1:0] scale;
		logic [7:0]         code;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part at reset settings, with light pressure on both sides
		idle_pct  = 15;
		stall_pct = 20;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_frame(MEASURE_CODE, 16'h0001, 1'b0);
		send_frame(MEASURE_CODE, OPEN_SPACE - 16'd1, 1'b0);
		send_frame(MEASURE_CODE, 16'h0000, 1'b0);
		send_frame(MEASURE_CODE, OPEN_SPACE, 1'b0);
		send_frame(8'h00, 16'h1234, 1'b0);
		send_frame(8'hFF, 16'h0000, 1'b1);
		// sync bytes as data in a bad frame, then a frame right behind it
		send_frame(SYNC_BYTE, {SYNC_BYTE, SYNC_BYTE}, 1'b1);
		send_frame(MEASURE_CODE, 16'h8000, 1'b0);

		for (int p = 0; p < PHASES; p++) begin
			limit = DRAW_TAB[p] ? LIMIT_W'($urandom) : LIMIT_W'(LIMIT_TAB[p]);
			scale = DRAW_TAB[p] ? SCALE_W'($urandom) : SCALE_W'(SCALE_TAB[p]);
			reconfigure(limit, scale);
			idle_pct  = IDLE_TAB[p];
			stall_pct = STALL_TAB[p];
			for (int f = 0; f < COUNT_TAB[p]; f++) begin
				// line noise and cut-off frames throw the framer off alignment
				if ($urandom_range(99) < 15) begin
					repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
				end else if ($urandom_range(99) < 5) begin
					send_byte(SYNC_BYTE);
					repeat ($urandom_range(0, 7)) send_byte(8'($urandom));
				end
				code = ($urandom_range(99) < 70) ? MEASURE_CODE : 8'($urandom);
				send_frame(code, pick_raw(), $urandom_range(99) < BAD_TAB[p]);
			end
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (frames_pending != 0) @(posedge clk);
		repeat (END_CYCLES) @(posedge clk);
		if (check_errors == 0 && frames_pending == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/rfp_pkg.sv
hw/rtl/rfp_framer.sv
hw/rtl/rfp_result.sv
hw/rtl/rangefinder_frame_parser_core.sv
tb/sv/rfp_frame_checker.sv
tb/sv/testbench.sv
